/* sv/dpgc_pkg.sv */
// Shared types and constants for the AC phase dimmer gate control block.
package dpgc_pkg;

    // Default channel count and field widths
    localparam int CHANNELS_DEF = 2;
    localparam int KIND_W       = 2;
    localparam int REQ_W        = 8;
    localparam int DUTY_W       = 7;
    localparam int PHASE_W      = 8;
    localparam int CFG_IDX_W    = 2;

    // Full-scale duty and half of it (center notch reference)
    localparam logic [REQ_W-1:0] FULL_DUTY = 8'd100;
    localparam logic [REQ_W-1:0] HALF_DUTY = 8'd50;

    // Transaction kinds on the input channel
    typedef enum logic [KIND_W-1:0] {
        KIND_TICK       = 2'd0,
        KIND_ZERO_CROSS = 2'd1,
        KIND_SET_DUTY   = 2'd2,
        KIND_RESERVED   = 2'd3
    } kind_t;

    // Per-channel gate modes
    typedef enum logic [1:0] {
        MODE_FORWARD = 2'd0,
        MODE_REVERSE = 2'd1,
        MODE_CENTER  = 2'd2,
        MODE_OFF     = 2'd3
    } mode_t;

    // Configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_ENABLE_MASK  = 2'd0,
        CFG_MODES        = 2'd1,
        CFG_INVERSE_MASK = 2'd2,
        CFG_UNUSED       = 2'd3
    } cfg_index_t;

    // Per-channel control bundle handed to the gate evaluator
    typedef struct packed {
        logic  enable;
        logic  invert;
        mode_t mode;
    } chan_ctrl_t;

endpackage

/* sv/ac_phase_dimmer_gate_control.sv */
// Top level of the multi-channel AC phase dimmer gate control block.
//
// Input channel (s_valid/s_ready) carries one transaction per event: a
// timer tick, a zero crossing or a set-duty request (s_channel,
// s_duty_value, saturated to 100 when stored). A zero crossing clears the
// 8-bit phase counter; a tick increments it and produces one result on the
// m_valid/m_ready channel: m_gate_levels, one gate bit per channel.
// Zero crossings and set-duty transactions produce no result.
// Configuration (enable mask, two-bit modes, inverse mask) is written through cfg_wr_en/cfg_index/cfg_wdata;
// the user must write it only while the block is idle; the block itself does not enforce this.
// A tick passes through two register stages, the input register and the
// result register, before its result shows.
// Throughput: one transaction per cycle; the input register and the result
// register move together whenever the result register is empty or taken.
// When the receiver stalls, the result is held and one more transaction may
// wait in the input register before s_ready drops.
// Reset (aresetn low, synchronous) clears the phase counter, all duties,
// all configuration registers and both valid flags.
module ac_phase_dimmer_gate_control #(
    parameter int CHANNELS = dpgc_pkg::CHANNELS_DEF
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    // Input channel
    input  logic                              s_valid,
    output logic                              s_ready,
    input  logic [dpgc_pkg::KIND_W-1:0]       s_kind,
    input  logic                              s_channel,
    input  logic [dpgc_pkg::REQ_W-1:0]        s_duty_value,
    // Result channel
    output logic                              m_valid,
    input  logic                              m_ready,
    output logic [CHANNELS-1:0]               m_gate_levels,
    // Configuration write port
    input  logic                              cfg_wr_en,
    input  logic [dpgc_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [2*CHANNELS-1:0]             cfg_wdata
);

    // Configuration registers
    logic [CHANNELS-1:0]   enable_mask_reg;
    logic [2*CHANNELS-1:0] modes_reg;
    logic [CHANNELS-1:0]   inverse_mask_reg;

    // Input register
    logic                         in_valid_reg;
    logic [dpgc_pkg::KIND_W-1:0]  in_kind_reg;
    logic                         in_channel_reg;
    logic [dpgc_pkg::REQ_W-1:0]   in_duty_reg;

    // Block state
    logic [dpgc_pkg::PHASE_W-1:0] phase_count_reg;
    logic [dpgc_pkg::PHASE_W-1:0] phase_count_next;
    logic [dpgc_pkg::DUTY_W-1:0]  duty_level_reg [CHANNELS];
    logic [dpgc_pkg::DUTY_W-1:0]  duty_sat;
    logic                         duty_wr;

    // Result register
    logic                         out_valid_reg;
    logic                         out_valid_next;
    logic [CHANNELS-1:0]          out_gate_reg;
    logic [CHANNELS-1:0]          gate_next;

    logic                         advance;
    logic                         is_tick;
    dpgc_pkg::kind_t              kind;
    dpgc_pkg::cfg_index_t         cfg_sel;

    assign kind    = dpgc_pkg::kind_t'(in_kind_reg);
    assign cfg_sel = dpgc_pkg::cfg_index_t'(cfg_index);

    // Both stages move when the result slot is free or being taken
    assign advance = !out_valid_reg || m_ready;
    assign s_ready = !in_valid_reg || advance;
    assign m_valid = out_valid_reg;
    assign m_gate_levels = out_gate_reg;

    // Configuration writes
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            enable_mask_reg  <= '0;
            modes_reg        <= '0;
            inverse_mask_reg <= '0;
        end else if (cfg_wr_en) begin
            unique case (cfg_sel)
                dpgc_pkg::CFG_ENABLE_MASK:  enable_mask_reg  <= cfg_wdata[CHANNELS-1:0];
                dpgc_pkg::CFG_MODES:        modes_reg        <= cfg_wdata;
                dpgc_pkg::CFG_INVERSE_MASK: inverse_mask_reg <= cfg_wdata[CHANNELS-1:0];
                dpgc_pkg::CFG_UNUSED:       ;
                default:                    ;
            endcase
        end
    end

    // Input register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_ready) begin
            in_valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_kind_reg    <= s_kind;
            in_channel_reg <= s_channel;
            in_duty_reg    <= s_duty_value;
        end
    end

    // Phase counter and duty write decode
    assign duty_sat = (in_duty_reg > dpgc_pkg::FULL_DUTY)
                    ? dpgc_pkg::FULL_DUTY[dpgc_pkg::DUTY_W-1:0]
                    : in_duty_reg[dpgc_pkg::DUTY_W-1:0];

    always_comb begin
        phase_count_next = phase_count_reg;
        duty_wr          = 1'b0;
        is_tick          = 1'b0;
        if (in_valid_reg && advance) begin
            unique case (kind)
                dpgc_pkg::KIND_TICK: begin
                    phase_count_next = phase_count_reg + 1'b1;
                    is_tick          = 1'b1;
                end
                dpgc_pkg::KIND_ZERO_CROSS: phase_count_next = '0;
                dpgc_pkg::KIND_SET_DUTY:   duty_wr = 1'b1;
                dpgc_pkg::KIND_RESERVED:   ;
                default:                   ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_count_reg <= '0;
            for (int c = 0; c < CHANNELS; c++) begin
                duty_level_reg[c] <= '0;
            end
        end else begin
            phase_count_reg <= phase_count_next;
            for (int c = 0; c < CHANNELS; c++) begin
                if (duty_wr && (int'(in_channel_reg) == c)) begin
                    duty_level_reg[c] <= duty_sat;
                end
            end
        end
    end

    // Per-channel gate evaluation on the incremented counter
    for (genvar c = 0; c < CHANNELS; c++) begin : g_chan
        dpgc_pkg::chan_ctrl_t ctrl;

        assign ctrl.enable = enable_mask_reg[c];
        assign ctrl.invert = inverse_mask_reg[c];
        assign ctrl.mode   = dpgc_pkg::mode_t'(modes_reg[2*c +: 2]);

        dpgc_chan_gate u_gate (
            .ctrl  (ctrl),
            .phase (phase_count_next),
            .duty  (duty_level_reg[c]),
            .gate  (gate_next[c])
        );
    end

    // Result register
    assign out_valid_next = advance ? is_tick : out_valid_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (is_tick) begin
            out_gate_reg <= gate_next;
        end
    end

endmodule

/* sv/dpgc_chan_gate.sv */
// Gate level evaluation for one dimmer channel.
module dpgc_chan_gate (
    input  dpgc_pkg::chan_ctrl_t              ctrl,
    input  logic [dpgc_pkg::PHASE_W-1:0]      phase,
    input  logic [dpgc_pkg::DUTY_W-1:0]       duty,
    output logic                              gate
);

    logic [dpgc_pkg::PHASE_W:0] fwd_sum;
    logic [dpgc_pkg::PHASE_W:0] ctr_sum;
    logic [dpgc_pkg::PHASE_W:0] ctr_limit;
    logic                       raw;

    // n + d >= 100  <=>  n >= 100 - d (duty never above 100)
    assign fwd_sum   = {1'b0, phase} + {2'b00, duty};
    // t = n - 50 + d/2, on when 0 <= t < d
    assign ctr_sum   = {1'b0, phase} + {3'b000, duty[dpgc_pkg::DUTY_W-1:1]};
    assign ctr_limit = {2'b00, duty} + {1'b0, dpgc_pkg::HALF_DUTY};

    // Raw level by mode
    always_comb begin
        unique case (ctrl.mode)
            dpgc_pkg::MODE_FORWARD: raw = (fwd_sum >= {1'b0, dpgc_pkg::FULL_DUTY});
            dpgc_pkg::MODE_REVERSE: raw = (phase <= {1'b0, duty});
            dpgc_pkg::MODE_CENTER:  raw = (ctr_sum >= {1'b0, dpgc_pkg::HALF_DUTY})
                                          && (ctr_sum < ctr_limit);
            dpgc_pkg::MODE_OFF:     raw = 1'b0;
            default:                raw = 1'b0;
        endcase
    end

    // Inversion only on an enabled channel
    assign gate = ctrl.enable & (raw ^ ctrl.invert);

endmodule

/* tb/tb.sv */
// Self-checking testbench for the AC phase dimmer gate control block.
`timescale 1ns / 1ps

module tb;
    import dpgc_pkg::*;

    localparam int NCH              = CHANNELS_DEF;
    localparam int WATCHDOG_LIMIT   = 4000;
    localparam int LONG_HOLD        = 60;
    localparam int NUM_SETTINGS     = 10;
    localparam int ITEMS_PER_PHASE  = 175;
    localparam int QUIET_AFTER      = 1600;
    localparam int DRAIN_CYCLES     = 3;

    // Gate level predictor and store of expected results
    class gate_level_scoreboard;
        logic [NCH-1:0]     enable_mask;
        logic [2*NCH-1:0]   mode_bits;
        logic [NCH-1:0]     invert_mask;
        logic [PHASE_W-1:0] phase_count;
        logic [DUTY_W-1:0]  duty_level [NCH];
        logic [NCH-1:0]     expected_levels [$];
        int                 errors;
        int                 checked;
        int                 ticks;
        int                 wraps;

        function new();
            enable_mask = '0;
            mode_bits   = '0;
            invert_mask = '0;
            phase_count = '0;
            for (int c = 0; c < NCH; c++) duty_level[c] = '0;
            errors  = 0;
            checked = 0;
            ticks   = 0;
            wraps   = 0;
        endfunction

        function int pending();
            return expected_levels.size();
        endfunction

        function void write_register(cfg_index_t idx, logic [2*NCH-1:0] val);
            case (idx)
                CFG_ENABLE_MASK:  enable_mask = val[NCH-1:0];
                CFG_MODES:        mode_bits   = val;
                CFG_INVERSE_MASK: invert_mask = val[NCH-1:0];
                default: ;
            endcase
        endfunction

        // Raw gate level of one channel for counter n and duty d
        function bit gate_on(mode_t m, logic [PHASE_W-1:0] n, logic [DUTY_W-1:0] d);
            int offset;
            offset = int'(n) - int'(HALF_DUTY) + int'(d) / 2;
            case (m)
                MODE_FORWARD: return int'(n) >= int'(FULL_DUTY) - int'(d);
                MODE_REVERSE: return int'(n) <= int'(d);
                MODE_CENTER:  return offset >= 0 && offset < int'(d);
                default:      return 1'b0;
            endcase
        endfunction

        // Called for every accepted input transaction
        function void note_input(kind_t k, logic ch, logic [REQ_W-1:0] dv);
            logic [NCH-1:0]   levels;
            logic [REQ_W-1:0] clamped;
            bit               on;
            case (k)
                KIND_TICK: begin
                    phase_count++;
                    ticks++;
                    if (phase_count == '0) wraps++;
                    levels = '0;
                    for (int c = 0; c < NCH; c++) begin
                        if (!enable_mask[c]) continue;
                        on = gate_on(mode_t'(mode_bits[2*c +: 2]), phase_count, duty_level[c]);
                        if (invert_mask[c]) on = !on;
                        levels[c] = on;
                    end
                    expected_levels.push_back(levels);
                end
                KIND_ZERO_CROSS: phase_count = '0;
                KIND_SET_DUTY: begin
                    clamped = (dv > FULL_DUTY) ? FULL_DUTY : dv;
                    if (int'(ch) < NCH) duty_level[ch] = clamped[DUTY_W-1:0];
                end
                default: ;
            endcase
        endfunction

        // Called for every accepted result transaction
        function void check_result(logic [NCH-1:0] got);
            logic [NCH-1:0] want;
            if (expected_levels.size() == 0) begin
                $error("gate_levels: unexpected result, expected none, got %b", got);
                errors++;
            end else begin
                want = expected_levels.pop_front();
                checked++;
                if (got !== want) begin
                    $error("gate_levels mismatch: expected %b, got %b", want, got);
                    errors++;
                end
            end
        endfunction
    endclass

    logic                 aclk;
    logic                 aresetn;
    logic                 s_valid;
    logic                 s_ready;
    logic [KIND_W-1:0]    s_kind;
    logic                 s_channel;
    logic [REQ_W-1:0]     s_duty_value;
    logic                 m_valid;
    logic                 m_ready;
    logic [NCH-1:0]       m_gate_levels;
    logic                 cfg_wr_en;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [2*NCH-1:0]     cfg_wdata;

    gate_level_scoreboard sb = new();
    bit quiet;
    bit hold_request;
    int sent_items;
    int settings_applied;
    int stall_cycles = 0;

    ac_phase_dimmer_gate_control #(.CHANNELS(NCH)) dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_kind        (s_kind),
        .s_channel     (s_channel),
        .s_duty_value  (s_duty_value),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_gate_levels (m_gate_levels),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_index     (cfg_index),
        .cfg_wdata     (cfg_wdata)
    );

    always #1 aclk = ~aclk;

    // Result monitor
    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) sb.check_result(m_gate_levels);
    end

    // Watchdog: cycles without any accepted transaction
    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready)) begin
            stall_cycles <= 0;
        end else begin
            stall_cycles <= stall_cycles + 1;
            if (stall_cycles >= WATCHDOG_LIMIT) begin
                $display("Timeout: no transaction for %0d cycles", WATCHDOG_LIMIT);
                $display("CHECKS FAILED");
                $finish;
            end
        end
    end

    // Receiver: random short stalls, one long hold on request
    initial begin
        m_ready = 1'b1;
        forever begin
            @(posedge aclk);
            if (hold_request) begin
                hold_request = 1'b0;
                m_ready <= 1'b0;
                repeat (LONG_HOLD) @(posedge aclk);
                m_ready <= 1'b1;
            end else if (!quiet && $urandom_range(0, 5) == 0) begin
                m_ready <= 1'b0;
                repeat ($urandom_range(1, 3)) @(posedge aclk);
                m_ready <= 1'b1;
            end
        end
    end

    // Offer one transaction, with an optional idle burst first
    task automatic send_item(kind_t k, logic ch, logic [REQ_W-1:0] dv);
        if (!quiet && $urandom_range(0, 7) == 0) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 3)) @(posedge aclk);
        end
        s_valid      <= 1'b1;
        s_kind       <= k;
        s_channel    <= ch;
        s_duty_value <= dv;
        do @(posedge aclk); while (!s_ready);
        sb.note_input(k, ch, dv);
        sent_items++;
    endtask

    // Stop offering and wait until every result is in and the block is empty
    task automatic settle();
        s_valid <= 1'b0;
        while (sb.pending() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    task automatic write_register(cfg_index_t idx, logic [2*NCH-1:0] val);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        @(posedge aclk);
        sb.write_register(idx, val);
    endtask

    task automatic configure(logic [2*NCH-1:0] en, logic [2*NCH-1:0] modes,
                             logic [2*NCH-1:0] inv);
        write_register(CFG_ENABLE_MASK, en);
        write_register(CFG_MODES, modes);
        write_register(CFG_INVERSE_MASK, inv);
        cfg_wr_en <= 1'b0;
        settings_applied++;
    endtask

    // Mostly in-range duties, sometimes above full scale
    function automatic logic [REQ_W-1:0] random_duty();
        if ($urandom_range(0, 4) == 0) return REQ_W'($urandom_range(0, 255));
        return REQ_W'($urandom_range(0, 100));
    endfunction

    // One mains half cycle: duty updates, usually a zero crossing, then a run of ticks
    task automatic run_half_cycle(int n_ticks, bit noisy);
        repeat ($urandom_range(0, 2)) send_item(KIND_SET_DUTY, 1'($urandom_range(0, 1)),
                                                random_duty());
        if ($urandom_range(0, 9) != 0)
            send_item(KIND_ZERO_CROSS, 1'($urandom_range(0, 1)),
                      REQ_W'($urandom_range(0, 255)));
        for (int i = 0; i < n_ticks; i++) begin
            // occasional noise in the middle of the run
            if (noisy && $urandom_range(0, 19) == 0) begin
                case ($urandom_range(0, 2))
                    0: send_item(KIND_SET_DUTY, 1'($urandom_range(0, 1)), random_duty());
                    1: send_item(KIND_RESERVED, 1'($urandom_range(0, 1)),
                                 REQ_W'($urandom_range(0, 255)));
                    default: send_item(KIND_ZERO_CROSS, 1'($urandom_range(0, 1)),
                                       REQ_W'($urandom_range(0, 255)));
                endcase
            end
            send_item(KIND_TICK, 1'($urandom_range(0, 1)), REQ_W'($urandom_range(0, 255)));
        end
    endtask

    // Main sequence
    initial begin
        int random_start;
        int phase_target;
        int n_ticks;
        bit noisy;

        aclk         = 1'b0;
        aresetn      = 1'b0;
        s_valid      = 1'b0;
        s_kind       = KIND_TICK;
        s_channel    = 1'b0;
        s_duty_value = '0;
        cfg_wr_en    = 1'b0;
        cfg_index    = CFG_ENABLE_MASK;
        cfg_wdata    = '0;
        quiet        = 1'b0;
        hold_request = 1'b0;
        sent_items   = 0;
        settings_applied = 0;
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed: reset settings, all channels disabled
        send_item(KIND_TICK, 1'b0, 8'd0);
        send_item(KIND_RESERVED, 1'b1, 8'hFF);
        send_item(KIND_SET_DUTY, 1'b0, 8'd255);
        send_item(KIND_SET_DUTY, 1'b1, 8'd100);
        send_item(KIND_TICK, 1'b1, 8'hFF);

        // Forward on channel 0, center notch on channel 1
        settle();
        configure(2'b11, {MODE_CENTER, MODE_FORWARD}, 2'b00);
        send_item(KIND_ZERO_CROSS, 1'b0, 8'd0);
        send_item(KIND_TICK, 1'b0, 8'd0);
        send_item(KIND_SET_DUTY, 1'b0, 8'd0);
        send_item(KIND_SET_DUTY, 1'b1, 8'd1);
        send_item(KIND_TICK, 1'b0, 8'd0);
        send_item(KIND_SET_DUTY, 1'b1, 8'd101);
        send_item(KIND_SET_DUTY, 1'b0, 8'd50);
        send_item(KIND_TICK, 1'b1, 8'd0);
        send_item(KIND_ZERO_CROSS, 1'b1, 8'hFF);
        send_item(KIND_TICK, 1'b0, 8'd0);

        // Inverted off-mode channel, inverted disabled channel, unused index
        settle();
        configure(2'b01, {MODE_REVERSE, MODE_OFF}, 2'b11);
        write_register(CFG_UNUSED, 4'b1111);
        cfg_wr_en <= 1'b0;
        send_item(KIND_TICK, 1'b0, 8'd0);
        send_item(KIND_SET_DUTY, 1'b1, 8'd77);
        send_item(KIND_TICK, 1'b1, 8'd0);
        send_item(KIND_RESERVED, 1'b0, 8'd0);

        // Both reverse, channel 1 inverted
        settle();
        configure(2'b11, {MODE_REVERSE, MODE_REVERSE}, 2'b10);
        send_item(KIND_ZERO_CROSS, 1'b0, 8'd0);
        send_item(KIND_TICK, 1'b0, 8'd0);
        send_item(KIND_TICK, 1'b1, 8'd0);

        // Random part: one register setting per phase
        random_start = sent_items;
        for (int ph = 0; ph < NUM_SETTINGS; ph++) begin
            settle();
            case (ph)
                0: configure(4'b0011, {MODE_FORWARD, MODE_FORWARD}, 4'b0000);
                1: configure(4'b1111, 4'b1111, 4'b1111);
                2: configure(4'b0000, {MODE_CENTER, MODE_CENTER}, 4'b0011);
                3: configure(4'b0011, {MODE_CENTER, MODE_REVERSE}, 4'b0000);
                default: configure(4'($urandom_range(0, 15)), 4'($urandom_range(0, 15)),
                                   4'($urandom_range(0, 15)));
            endcase
            // receiver holds off while ticks keep coming
            if (ph == 1) hold_request = 1'b1;
            phase_target = sent_items + ITEMS_PER_PHASE;
            while (sent_items < phase_target) begin
                noisy = 1'b1;
                if (ph == 0 && sent_items == random_start) begin
                    n_ticks = 260;    // clean run, forces a counter wrap
                    noisy   = 1'b0;
                end else begin
                    if ($urandom_range(0, 7) == 0)
                        n_ticks = $urandom_range(250, 290);
                    else
                        n_ticks = $urandom_range(90, 120);
                    if (n_ticks > phase_target - sent_items)
                        n_ticks = phase_target - sent_items;
                end
                if (sent_items - random_start > QUIET_AFTER) quiet = 1'b1;
                run_half_cycle(n_ticks, noisy);
            end
        end

        // Drain and let any stray result show up
        s_valid <= 1'b0;
        quiet = 1'b1;
        while (sb.pending() != 0) @(posedge aclk);
        repeat (8) @(posedge aclk);

        $display("Sent %0d transactions (%0d ticks, %0d counter wraps); %0d gate results checked.",
                 sent_items, sb.ticks, sb.wraps, sb.checked);
        $display("Went through %0d register settings with random stalls on both channels.",
                 settings_applied);
        if (sb.errors == 0 && sb.pending() == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule
